// ===== hw/rtl/segment_tree_range_reduce_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment tree range reduce unit
// Short forms for same-cycle and next-cycle implications, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_REDUCE_UNIT_ASSERT_SVH
`define SEGMENT_TREE_RANGE_REDUCE_UNIT_ASSERT_SVH

`define STRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define STRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stru_pkg.sv =====
// ----------------------------------------------------------------------------
// stru_pkg
// Shared types, codes and constants of the segment tree range reduce unit.
// ----------------------------------------------------------------------------
package stru_pkg;

    localparam int LEAVES_DEFAULT = 1024;
    localparam int DATA_W         = 32;

    typedef enum logic [1:0] {
        MODE_SUM,
        MODE_PROD,
        MODE_MAX,
        MODE_MIN
    } t_mode;

    typedef enum logic [1:0] {
        KIND_SET,
        KIND_QUERY,
        KIND_READ
    } t_kind;

    function automatic logic [DATA_W-1:0] identity(input t_mode mode);
        logic [DATA_W-1:0] id;
        unique case (mode)
            MODE_SUM:  id = 32'h0000_0000;
            MODE_PROD: id = 32'h0000_0001;
            MODE_MAX:  id = 32'h8000_0000;
            MODE_MIN:  id = 32'h7FFF_FFFF;
            default:   id = 32'h0000_0000;
        endcase
        return id;
    endfunction

endpackage

// ===== hw/rtl/stru_join.sv =====
// ----------------------------------------------------------------------------
// stru_join
// Combine operator of the tree: wrapping sum or product, signed max or min.
// ----------------------------------------------------------------------------
module stru_join (
    input  stru_pkg::t_mode                i_mode,
    input  logic [stru_pkg::DATA_W-1:0]    i_a,
    input  logic [stru_pkg::DATA_W-1:0]    i_b,
    output logic [stru_pkg::DATA_W-1:0]    o_y
);

    logic [2*stru_pkg::DATA_W-1:0] prod;

    assign prod = i_a * i_b;

    always_comb begin
        unique case (i_mode)
            stru_pkg::MODE_SUM:  o_y = i_a + i_b;
            stru_pkg::MODE_PROD: o_y = prod[stru_pkg::DATA_W-1:0];
            stru_pkg::MODE_MAX:  o_y = ($signed(i_a) >= $signed(i_b)) ? i_a : i_b;
            stru_pkg::MODE_MIN:  o_y = ($signed(i_a) <= $signed(i_b)) ? i_a : i_b;
            default:             o_y = i_a + i_b;
        endcase
    end

endmodule

// ===== hw/rtl/segment_tree_range_reduce_unit.sv =====
// ----------------------------------------------------------------------------
// segment_tree_range_reduce_unit
// Segment tree over LEAVES leaves held in one synchronous memory with one write and one read port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                       Payload
// in        sink       i_in_valid / o_in_stall         i_kind, i_left_index,
//                                                      i_right_end, i_leaf_value
// out       source     o_out_valid / i_out_stall       o_result_value, o_status
// cfg       sink       i_cfg_valid / o_cfg_ready       i_combine_mode
//
// One request at a time; every memory read has an issue step and a step that uses the read data.
// A set writes the leaf and then each ancestor up to the root; a read fetches one leaf.
// SPAN is LEAVES rounded up to a power of two; the memory holds 2*SPAN entries.
// Reset and every mode write start a clearing pass over all 2*SPAN entries.
// The result register holds while the output is stalled.
// ----------------------------------------------------------------------------
`include "segment_tree_range_reduce_unit_assert.svh"

module segment_tree_range_reduce_unit #(
    parameter int LEAVES = stru_pkg::LEAVES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic [10:0]                       i_left_index,
    input  logic [10:0]                       i_right_end,
    input  logic signed [stru_pkg::DATA_W-1:0] i_leaf_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [stru_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_combine_mode
);

    localparam int SPAN  = 1 << $clog2(LEAVES);
    localparam int NODES = 2 * SPAN;
    localparam int AW    = $clog2(NODES);
    localparam int PW    = AW + 1;
    localparam int DW    = stru_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_QL, S_QR, S_QACC, S_URD, S_UWB, S_RWAIT, S_OUT
    } t_state;

    t_state            r_state, n_state;
    stru_pkg::t_mode   r_mode, n_mode;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_k, n_k;
    logic [PW-1:0]     r_l, n_l;
    logic [PW-1:0]     r_r, n_r;
    logic [DW-1:0]     r_acc, n_acc;
    logic              r_from_r, n_from_r;
    logic [DW-1:0]     r_res, n_res;
    logic              r_st, n_st;
    logic [DW-1:0]     r_rdata;

    logic [DW-1:0]     r_mem [0:NODES-1];
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DW-1:0]     mem_wd;
    logic [AW-1:0]     mem_ra;

    logic [DW-1:0]     join_y;
    logic [31:0]       sat_l, sat_r;
    logic              in_acc, cfg_acc;

    stru_join u_join (
        .i_mode (r_mode),
        .i_a    (r_acc),
        .i_b    (r_rdata),
        .o_y    (join_y)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign sat_l   = (32'(i_left_index) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(i_left_index);
    assign sat_r   = (32'(i_right_end) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(i_right_end);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_l      = r_l;
        n_r      = r_r;
        n_acc    = r_acc;
        n_from_r = r_from_r;
        n_res    = r_res;
        n_st     = r_st;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_ra   = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = stru_pkg::identity(r_mode);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    n_st  = 1'b0;
                    unique case (i_kind)
                        stru_pkg::KIND_SET: begin
                            if (32'(i_left_index) >= 32'(LEAVES)) begin
                                n_st    = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_k     = AW'(SPAN) + AW'(i_left_index);
                                mem_we  = 1'b1;
                                mem_wa  = AW'(SPAN) + AW'(i_left_index);
                                mem_wd  = i_leaf_value;
                                n_acc   = i_leaf_value;
                                n_state = S_URD;
                            end
                        end
                        stru_pkg::KIND_QUERY: begin
                            n_acc   = stru_pkg::identity(r_mode);
                            n_l     = PW'(sat_l) + PW'(SPAN);
                            n_r     = PW'(sat_r) + PW'(SPAN);
                            n_state = S_QL;
                        end
                        stru_pkg::KIND_READ: begin
                            if (32'(i_left_index) >= 32'(LEAVES)) begin
                                n_st    = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                mem_ra  = AW'(SPAN) + AW'(i_left_index);
                                n_state = S_RWAIT;
                            end
                        end
                        default: begin
                            n_st    = 1'b1;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_QL: begin
                if (r_l >= r_r) begin
                    n_res   = r_acc;
                    n_state = S_OUT;
                end else if (r_l[0]) begin
                    mem_ra   = r_l[AW-1:0];
                    n_l      = r_l + 1'b1;
                    n_from_r = 1'b0;
                    n_state  = S_QACC;
                end else begin
                    n_state = S_QR;
                end
            end
            S_QR: begin
                if (r_r[0]) begin
                    n_r      = r_r - 1'b1;
                    mem_ra   = AW'(r_r - 1'b1);
                    n_from_r = 1'b1;
                    n_state  = S_QACC;
                end else begin
                    n_l     = r_l >> 1;
                    n_r     = r_r >> 1;
                    n_state = S_QL;
                end
            end
            S_QACC: begin
                n_acc = join_y;
                if (r_from_r) begin
                    n_l     = r_l >> 1;
                    n_r     = r_r >> 1;
                    n_state = S_QL;
                end else begin
                    n_state = S_QR;
                end
            end
            S_URD: begin
                if (r_k == AW'(1)) begin
                    n_state = S_OUT;
                end else begin
                    mem_ra  = r_k ^ AW'(1);
                    n_state = S_UWB;
                end
            end
            S_UWB: begin
                n_acc   = join_y;
                mem_we  = 1'b1;
                mem_wa  = r_k >> 1;
                mem_wd  = join_y;
                n_k     = r_k >> 1;
                n_state = S_URD;
            end
            S_RWAIT: begin
                n_res   = r_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cfg_acc) begin
            n_mode  = stru_pkg::t_mode'(i_combine_mode);
            n_cnt   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= stru_pkg::MODE_SUM;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
        end
        r_k      <= n_k;
        r_l      <= n_l;
        r_r      <= n_r;
        r_acc    <= n_acc;
        r_from_r <= n_from_r;
        r_res    <= n_res;
        r_st     <= n_st;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = (r_state == S_OUT);
    assign o_result_value = r_res;
    assign o_status       = r_st;

    `STRU_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "input accepted while a result is pending")
    `STRU_ASSERT_NOW(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLEAR, o_in_stall,
        "input accepted during clearing pass")
    `STRU_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_out_valid && !i_out_stall,
        !o_out_valid, "result delivered twice")

endmodule
